@@ rtl/dynamic_priority_scheduler_assert.svh @@
// Assertion macros used by the scheduler top level.
`ifndef DYNAMIC_PRIORITY_SCHEDULER_ASSERT_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

`define DPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scheduler assertion failed");

`define DPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scheduler assertion failed");

`else

`define DPS_ASSERT(lbl, clk, rst_n, prop)

`define DPS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/dps_pkg.sv @@
// Types and constants shared by the scheduler modules.
package dps_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic       FUNC_ADD  = 1'b0;
    localparam logic       FUNC_TICK = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [7:0] PRIO_MIN = -8'sd128;

    typedef struct packed {
        logic              func;
        logic [7:0]        task_id;
        logic signed [7:0] priority_req;
        logic [7:0]        run_time;
    } t_in_word;

    typedef struct packed {
        logic [7:0] dispatched_id;
        logic       dispatched_valid;
        logic       task_finished;
        logic [1:0] status;
        logic [4:0] tasks_waiting;
    } t_out_word;

    typedef struct packed {
        logic [7:0]        id;
        logic signed [7:0] prio;
        logic [7:0]        remain;
    } t_entry;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_POP
    } t_chain_op;

    typedef struct packed {
        t_chain_op op;
        t_entry    entry;
    } t_chain_ctl;

endpackage

@@ rtl/dps_slot.sv @@
// One entry of the ready table: holds, shifts or takes a new task.
module dps_slot
    import dps_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_occupied,
    input  t_entry     i_left,
    input  logic       i_left_keep,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_keep
);

    t_entry r_entry;

    assign o_keep  = i_occupied && (r_entry.prio >= i_ctl.entry.prio);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CH_INSERT: begin
                if (!o_keep) begin
                    r_entry <= i_left_keep ? i_ctl.entry : i_left;
                end
            end
            CH_POP: begin
                r_entry <= i_right;
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

endmodule

@@ rtl/dps_chain.sv @@
// Row of table slots ordered by priority, highest at slot zero.
module dps_chain
    import dps_pkg::*;
(
    input  logic             i_clk,
    input  t_chain_ctl       i_ctl,
    input  logic [CNT_W-1:0] i_count,
    output t_entry           o_head
);

    t_entry entries [DEPTH];
    logic   keeps   [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_slot
        t_entry left_entry;
        t_entry right_entry;
        logic   left_keep;
        logic   occupied;

        assign occupied = CNT_W'(k) < i_count;

        if (k == 0) begin : g_first
            assign left_entry = '0;
            assign left_keep  = 1'b1;
        end else begin : g_mid
            assign left_entry = entries[k-1];
            assign left_keep  = keeps[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = entries[k+1];
        end

        dps_slot u_slot (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_occupied  (occupied),
            .i_left      (left_entry),
            .i_left_keep (left_keep),
            .i_right     (right_entry),
            .o_entry     (entries[k]),
            .o_keep      (keeps[k])
        );
    end

    assign o_head = entries[0];

endmodule

@@ rtl/dynamic_priority_scheduler.sv @@
// Top level of the priority scheduler with aging.
//
// The input channel (i_in_valid, o_in_stall, i_in_word) carries add and tick
// words. The output channel (o_out_valid, i_out_stall, o_out_word) returns
// exactly one result word per input word, in order.
// An add shifts the task into the slot row in the cycle it is accepted,
// and its result is registered at the same edge.
// A tick whose task still has time left pops the head slot at the
// accepting edge and registers its result, then shifts the aged task
// back into the row in the next cycle, during which the input is
// stalled. A tick that finishes its task or finds the table empty, and an add
// to a full table, complete at the accepting edge.
// Throughput is one word per cycle while the receiver does not stall, except
// a reinserting tick, which holds the input for the single insert path.
// A result becomes valid in the cycle after its word is accepted.
// Reset empties the table by clearing the count; slot contents are not cleared.
// While the receiver stalls a pending result, the input is stalled too,
// and the table keeps its contents unless a reinsert is still pending.
module dynamic_priority_scheduler
    import dps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    `include "dynamic_priority_scheduler_assert.svh"

    typedef enum logic {
        S_IDLE,
        S_REINS
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    t_entry           r_reins;
    logic             r_out_valid;
    t_out_word        r_out;

    t_chain_ctl       chain_ctl;
    t_entry           head;
    t_entry           new_entry;
    t_entry           aged;
    logic             in_acc;
    logic             out_free;
    logic             is_full;
    logic             is_empty;
    logic             head_done;
    logic [CNT_W-1:0] count_after;
    t_out_word        result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign head_done = (head.remain <= 8'd1);

    assign new_entry.id     = i_in_word.task_id;
    assign new_entry.prio   = i_in_word.priority_req;
    assign new_entry.remain = (i_in_word.run_time == 8'd0) ? 8'd1 : i_in_word.run_time;

    assign aged.id     = head.id;
    assign aged.prio   = (head.prio == PRIO_MIN) ? PRIO_MIN : head.prio - 8'sd1;
    assign aged.remain = head.remain - 8'd1;

    always_comb begin
        chain_ctl.op    = CH_HOLD;
        chain_ctl.entry = new_entry;
        result          = '0;
        count_after     = r_count;
        if (r_state == S_REINS) begin
            chain_ctl.op    = CH_INSERT;
            chain_ctl.entry = r_reins;
        end else if (in_acc) begin
            if (i_in_word.func == FUNC_ADD) begin
                if (is_full) begin
                    result.status = ST_FULL;
                end else begin
                    chain_ctl.op = CH_INSERT;
                    count_after  = r_count + CNT_W'(1);
                end
            end else if (is_empty) begin
                result.status = ST_EMPTY;
            end else begin
                chain_ctl.op            = CH_POP;
                result.dispatched_id    = head.id;
                result.dispatched_valid = 1'b1;
                result.task_finished    = head_done;
                if (head_done) begin
                    count_after = r_count - CNT_W'(1);
                end
            end
        end
        result.tasks_waiting = 5'(count_after);
    end

    dps_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (chain_ctl),
        .i_count (r_count),
        .o_head  (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_out_valid <= 1'b1;
                        if (chain_ctl.op == CH_POP) begin
                            r_count <= r_count - CNT_W'(1);
                            if (!head_done) begin
                                r_state <= S_REINS;
                            end
                        end else if (chain_ctl.op == CH_INSERT) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end else if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_REINS: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_IDLE;
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= result;
        end
        if ((r_state == S_IDLE) && (chain_ctl.op == CH_POP)) begin
            r_reins <= aged;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `DPS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `DPS_ASSERT(a_reins_stalls, i_clk, i_rst_n, (r_state == S_REINS) |-> o_in_stall)
    `DPS_ASSERT(a_tick_reinserts, i_clk, i_rst_n,
        (in_acc && i_in_word.func == FUNC_TICK && !is_empty && !head_done) |=> (r_state == S_REINS))
    `DPS_ASSERT(a_dispatch_ok, i_clk, i_rst_n,
        (r_out_valid && r_out.dispatched_valid) |-> (r_out.status == ST_OK))

endmodule
